@@ src/psbs_pkg.sv @@
// Package for the prefix-sum bucket search: sizes, codes and types.
`default_nettype none

package psbs_pkg;

    // Table size and label width
    localparam int MAX_BUCKETS = 1024;
    localparam int LABEL_BITS  = 26;

    // Derived widths: count holds 0..MAX_BUCKETS, address holds 0..MAX_BUCKETS-1
    localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
    localparam int ADDR_W = $clog2(MAX_BUCKETS);

    // Fixed field widths of the channels
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 11;

    typedef logic [FUNC_W-1:0]     func_t;
    typedef logic [LABEL_BITS-1:0] label_t;
    typedef logic [IDX_W-1:0]      idx_t;

    // Command codes
    localparam func_t FUNC_CLEAR  = FUNC_W'(0);
    localparam func_t FUNC_APPEND = FUNC_W'(1);
    localparam func_t FUNC_QUERY  = FUNC_W'(2);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HOLD
    } state_t;

endpackage : psbs_pkg

`default_nettype wire

@@ src/psbs_cmd_if.sv @@
// Command channel: valid/ready handshake carrying func and value.
`default_nettype none

interface psbs_cmd_if;
    import psbs_pkg::*;

    logic   valid;
    logic   ready;
    func_t  func;
    label_t value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface : psbs_cmd_if

`default_nettype wire

@@ src/psbs_rsp_if.sv @@
// Result channel: valid/ready handshake carrying bucket_index and found.
`default_nettype none

interface psbs_rsp_if;
    import psbs_pkg::*;

    logic valid;
    logic ready;
    idx_t bucket_index;
    logic found;

    modport source (output valid, output bucket_index, output found, input ready);
    modport sink   (input valid, input bucket_index, input found, output ready);
endinterface : psbs_rsp_if

`default_nettype wire

@@ src/psbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : psbs_ram

`default_nettype wire

@@ src/prefix_sum_bucket_search_core.sv @@
// Top level: bucket-end table in RAM with append, clear and binary-search query.
//
//  channel | dir | transfer                  | payload
//  --------+-----+---------------------------+------------------------------
//  cmd     | in  | cmd.valid && cmd.ready    | func, value
//  rsp     | out | rsp.valid && rsp.ready    | bucket_index, found
//
// Clear and append complete in ST_IDLE as they are accepted. A query starts in
// ST_IDLE, makes one RAM read per search step in ST_SEARCH (up to ceil(log2(count+1))
// steps, 11 at a full table), and hands over to the result register from ST_HOLD.
// Labels of zero or beyond the running total skip the search and go to ST_HOLD.
// The pace is set by the single read port of the bucket-end RAM, one read per step.
// rst_n clears count, total and control; the RAM is not cleared, only entries
// below the count are ever read. A stalled result holds the block in ST_HOLD.
`default_nettype none

module prefix_sum_bucket_search_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    psbs_cmd_if.sink    cmd,
    psbs_rsp_if.source  rsp
);
    import psbs_pkg::*;

    // Control state
    state_t             state_reg,       state_next;
    logic [CNT_W-1:0]   count_reg,       count_next;
    label_t             total_reg,       total_next;
    logic               out_valid_reg,   out_valid_next;

    // Search and result payload
    label_t             label_reg,       label_next;
    logic [CNT_W-1:0]   lo_reg,          lo_next;
    logic [CNT_W-1:0]   hi_reg,          hi_next;
    logic [ADDR_W-1:0]  mid_reg,         mid_next;
    idx_t               res_idx_reg,     res_idx_next;
    logic               res_found_reg,   res_found_next;
    idx_t               out_idx_reg,     out_idx_next;
    logic               out_found_reg,   out_found_next;

    // RAM port signals
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    label_t             ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    label_t             ram_rdata;

    // Helpers
    logic [LABEL_BITS:0] sum_wide;
    label_t              sum_sat;
    logic [CNT_W-1:0]    step_lo;
    logic [CNT_W-1:0]    step_hi;
    logic [CNT_W:0]      mid_sum;
    logic [CNT_W:0]      idx_sum;
    logic                out_free;

    psbs_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (MAX_BUCKETS)
    ) u_end_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Saturating running total for appends
    assign sum_wide = {1'b0, total_reg} + {1'b0, cmd.value};
    assign sum_sat  = sum_wide[LABEL_BITS] ? '1 : sum_wide[LABEL_BITS-1:0];

    // One lower-bound step: first bucket whose end is at or above the label
    always_comb
    begin
        step_lo = lo_reg;
        step_hi = hi_reg;
        if (ram_rdata >= label_reg)
        begin
            step_hi = CNT_W'(mid_reg);
        end
        else
        begin
            step_lo = CNT_W'(mid_reg) + CNT_W'(1);
        end
    end

    assign mid_sum  = {1'b0, step_lo} + {1'b0, step_hi};
    assign idx_sum  = {1'b0, step_lo} + (CNT_W+1)'(1);
    assign out_free = !out_valid_reg || rsp.ready;

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        label_next     = label_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_idx_next   = res_idx_reg;
        res_found_next = res_found_reg;
        out_idx_next   = out_idx_reg;
        out_found_next = out_found_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata = sum_sat;
        ram_re    = 1'b0;
        ram_raddr = mid_reg;

        cmd.ready = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd.func)
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        FUNC_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_BUCKETS))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                total_next = sum_sat;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            label_next = cmd.value;
                            if ((cmd.value == '0) || (cmd.value > total_reg))
                            begin
                                // label outside every bucket
                                res_idx_next   = '0;
                                res_found_next = 1'b0;
                                state_next     = ST_HOLD;
                            end
                            else
                            begin
                                // total above zero, so count is at least one
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = ADDR_W'(count_reg >> 1);
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(count_reg >> 1);
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi)
                begin
                    mid_next  = mid_sum[ADDR_W:1];
                    ram_re    = 1'b1;
                    ram_raddr = mid_sum[ADDR_W:1];
                end
                else
                begin
                    // label lies within the total, so the bound is a hit
                    res_idx_next   = idx_sum[IDX_W-1:0];
                    res_found_next = 1'b1;
                    state_next     = ST_HOLD;
                end
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_found_next = res_found_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        label_reg     <= label_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        res_idx_reg   <= res_idx_next;
        res_found_reg <= res_found_next;
        out_idx_reg   <= out_idx_next;
        out_found_reg <= out_found_next;
    end

    // Result channel
    assign rsp.valid        = out_valid_reg;
    assign rsp.bucket_index = out_idx_reg;
    assign rsp.found        = out_found_reg;

endmodule : prefix_sum_bucket_search_core

`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for prefix_sum_bucket_search_core: directed table, random sequences, result checks.
`timescale 1ns / 100ps

module testbench;
    import psbs_pkg::*;

    // Code with no command behind it: the block drops such transfers
    localparam func_t FUNC_UNUSED = FUNC_W'(3);

    localparam logic [LABEL_BITS:0] LABEL_MAX = {1'b0, {LABEL_BITS{1'b1}}};
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 16;
    localparam int PRINT_LIMIT    = 20;

    typedef struct packed {
        idx_t bucket_index;
        logic found;
    } lookup_t;

    typedef struct packed {
        func_t  func;
        label_t value;
        logic   typed;
        idx_t   bucket_index;
        logic   found;
    } stim_row_t;

    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    logic clk;
    logic rst_n;

    psbs_cmd_if cmd_ch ();
    psbs_rsp_if rsp_ch ();

    prefix_sum_bucket_search_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the bucket table
    label_t ends_tbl [MAX_BUCKETS];
    int     n_buckets;
    label_t label_sum;

    lookup_t expected_lookups [$];

    // Run control shared between the processes
    bit idle_on;
    bit long_hold_req;

    // Counters
    int n_errors;
    int n_items;
    int n_appends;
    int n_full_drops;
    int n_saturated;
    int n_clears;
    int n_queries;
    int n_hits;
    int n_noise;
    int peak_buckets;

    // Directed rows: extremes, empty and saturated buckets, unused code, clear
    stim_row_t directed_rows [25] = '{
        // empty table: nothing is found
        '{FUNC_QUERY,  26'd0,          TYPED, 11'd0, 1'b0},
        '{FUNC_QUERY,  26'd5,          TYPED, 11'd0, 1'b0},
        '{FUNC_QUERY,  26'h3FFFFFF,    TYPED, 11'd0, 1'b0},
        // buckets 1..3, the middle one empty
        '{FUNC_APPEND, 26'd3,          PRED,  11'd0, 1'b0},
        '{FUNC_APPEND, 26'd0,          PRED,  11'd0, 1'b0},
        '{FUNC_APPEND, 26'd2,          PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'd0,          TYPED, 11'd0, 1'b0},
        '{FUNC_QUERY,  26'd1,          TYPED, 11'd1, 1'b1},
        '{FUNC_QUERY,  26'd3,          TYPED, 11'd1, 1'b1},
        '{FUNC_QUERY,  26'd4,          PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'd5,          PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'd6,          TYPED, 11'd0, 1'b0},
        '{FUNC_UNUSED, 26'h155AA55,    PRED,  11'd0, 1'b0},
        // running total clamps at the top label
        '{FUNC_APPEND, 26'h3FFFFFF,    PRED,  11'd0, 1'b0},
        '{FUNC_APPEND, 26'd5,          PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'h3FFFFFF,    PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'h3FFFFFE,    PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'd6,          PRED,  11'd0, 1'b0},
        '{FUNC_CLEAR,  26'h3FFFFFF,    PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'd1,          TYPED, 11'd0, 1'b0},
        // two buckets that add up exactly to the top label
        '{FUNC_APPEND, 26'h2AAAAAA,    PRED,  11'd0, 1'b0},
        '{FUNC_APPEND, 26'h1555555,    PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'h2AAAAAA,    PRED,  11'd0, 1'b0},
        '{FUNC_QUERY,  26'h2AAAAAB,    PRED,  11'd0, 1'b0},
        '{FUNC_UNUSED, 26'h3FFFFFF,    PRED,  11'd0, 1'b0}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("prefix_sum_bucket_search_core test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Binary search over the shadow ends, probing bucket ranges rather than the block's lower bound
    function automatic lookup_t locate_label(input label_t lbl);
        int lo;
        int hi;
        int mid;
        logic [LABEL_BITS:0] bucket_lo;
        logic [LABEL_BITS:0] bucket_hi;
        lookup_t r;
        r  = '0;
        lo = 0;
        hi = n_buckets - 1;
        while (lo <= hi)
        begin
            mid       = (lo + hi) / 2;
            bucket_lo = (mid == 0) ? (LABEL_BITS+1)'(1)
                                   : {1'b0, ends_tbl[mid-1]} + (LABEL_BITS+1)'(1);
            bucket_hi = {1'b0, ends_tbl[mid]};
            if (bucket_lo <= lbl && bucket_hi >= lbl)
            begin
                r.bucket_index = idx_t'(mid + 1);
                r.found        = 1'b1;
                break;
            end
            else if (bucket_lo > lbl)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    // Update the shadow table for one command; queries yield one result
    task automatic apply_command(input func_t f, input label_t v,
                                 output bit has_res, output lookup_t res);
        logic [LABEL_BITS:0] sum;
        has_res = 1'b0;
        res     = '0;
        case (f)
            FUNC_CLEAR:
            begin
                n_buckets = 0;
                label_sum = '0;
                n_clears++;
            end
            FUNC_APPEND:
            begin
                n_appends++;
                if (n_buckets >= MAX_BUCKETS)
                    n_full_drops++;
                else
                begin
                    sum = {1'b0, label_sum} + v;
                    if (sum > LABEL_MAX)
                    begin
                        sum = LABEL_MAX;
                        n_saturated++;
                    end
                    label_sum = sum[LABEL_BITS-1:0];
                    ends_tbl[n_buckets] = label_sum;
                    n_buckets++;
                    if (n_buckets > peak_buckets)
                        peak_buckets = n_buckets;
                end
            end
            FUNC_QUERY:
            begin
                res     = locate_label(v);
                has_res = 1'b1;
                n_queries++;
                if (res.found)
                    n_hits++;
            end
            default:
                n_noise++;
        endcase
    endtask

    function automatic int pick_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 6);
        return 0;
    endfunction

    // Offer one command until it transfers, then predict its outcome
    task automatic send_item(input func_t f, input label_t v,
                             input bit typed, input lookup_t typed_res);
        bit      has_res;
        lookup_t res;
        int      gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.func  <= func_t'($urandom);
            cmd_ch.value <= label_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= f;
        cmd_ch.value <= v;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        apply_command(f, v, has_res, res);
        if (has_res)
            expected_lookups.insert(expected_lookups.size(), typed ? typed_res : res);
        if (f != FUNC_UNUSED)
            n_items++;
    endtask

    task automatic send_cmd(input func_t f, input label_t v);
        send_item(f, v, 1'b0, '0);
    endtask

    // Labels near bucket edges, past the total, zero, or anywhere
    function automatic label_t pick_label();
        int unsigned r;
        int          k;
        r = $urandom_range(0, 99);
        if (n_buckets == 0 || r < 10)
            return label_t'($urandom);
        if (r < 15)
            return '0;
        if (r < 45)
        begin
            k = $urandom_range(0, n_buckets - 1);
            return ends_tbl[k] + label_t'($urandom_range(0, 1));
        end
        if (r < 55 || label_sum == 0)
            return label_sum + label_t'($urandom_range(0, 2));
        return label_t'($urandom_range(1, label_sum));
    endfunction

    function automatic label_t pick_size(input int size_max, input bit wide);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (wide && r < 8)
            return label_t'($urandom >> $urandom_range(0, 25));
        if (r < 15)
            return '0;
        return label_t'($urandom_range(0, size_max));
    endfunction

    // A clear, then mixed appends and queries; noisy runs can skip it, add stray codes and clears
    task automatic run_block(input int n_app, input int n_qry, input int size_max,
                             input bit wide, input bit noisy, input int app_pct);
        int unsigned r;
        if (!noisy || $urandom_range(0, 4) != 0)
            send_cmd(FUNC_CLEAR, label_t'($urandom));
        while (n_app > 0 || n_qry > 0)
        begin
            r = $urandom_range(0, 99);
            if (noisy && r < 3)
                send_cmd(FUNC_UNUSED, label_t'($urandom));
            else if (noisy && r < 5)
                send_cmd(FUNC_CLEAR, label_t'($urandom));
            else if (n_app > 0 && (n_qry == 0 || $urandom_range(0, 99) < app_pct))
            begin
                send_cmd(FUNC_APPEND, pick_size(size_max, wide));
                n_app--;
            end
            else
            begin
                send_cmd(FUNC_QUERY, pick_label());
                n_qry--;
            end
        end
    endtask

    // Result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_lookups.size() == 0)
                report_mismatch($sformatf("unexpected result index=%0d found=%0b",
                                          rsp_ch.bucket_index, rsp_ch.found));
            else
            begin
                want = expected_lookups.pop_front();
                if (rsp_ch.bucket_index !== want.bucket_index)
                    report_mismatch($sformatf("bucket_index got %0d want %0d",
                                              rsp_ch.bucket_index, want.bucket_index));
                if (rsp_ch.found !== want.found)
                    report_mismatch($sformatf("found got %0b want %0b",
                                              rsp_ch.found, want.found));
            end
        end
    end

    // Reset, stimulus and end of run
    initial
    begin
        lookup_t row_res;
        int      waited;
        rst_n         = 1'b0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        n_buckets     = 0;
        label_sum     = '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func  <= FUNC_CLEAR;
        cmd_ch.value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            row_res.bucket_index = directed_rows[i].bucket_index;
            row_res.found        = directed_rows[i].found;
            send_item(directed_rows[i].func, directed_rows[i].value,
                      directed_rows[i].typed, row_res);
        end

        // Short random sequences with idling on both sides
        while (n_items < 80)
            run_block($urandom_range(1, 24), $urandom_range(2, 16), 20, 1'b1, 1'b1, 75);

        // Receiver holds off while queries keep coming, so the input stalls
        long_hold_req = 1'b1;
        run_block(4, 20, 20, 1'b0, 1'b1, 60);

        // Sender waits for every outstanding result
        cmd_ch.valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);

        while (n_items < 150)
            run_block($urandom_range(1, 24), $urandom_range(2, 16), 20, 1'b1, 1'b1, 75);

        // Fill the table past capacity, querying along the way
        run_block(MAX_BUCKETS + 6, 40, 3, 1'b0, 1'b0, 95);

        // Final stretch without idling
        idle_on = 1'b0;
        do
            run_block($urandom_range(1, 24), $urandom_range(2, 16), 20, 1'b1, 1'b1, 75);
        while (n_items < 1270);

        // Drain
        cmd_ch.valid <= 1'b0;
        waited = 0;
        while (expected_lookups.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_lookups.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_lookups.size()));

        $display("Covered %0d commands: %0d appends (%0d on a full table, %0d clamped),",
                 n_items, n_appends, n_full_drops, n_saturated);
        $display("  %0d clears, %0d lookups (%0d hits), %0d stray codes, peak %0d buckets",
                 n_clears, n_queries, n_hits, n_noise, peak_buckets);
        if (n_errors == 0)
            $display("prefix_sum_bucket_search_core test passed");
        else
            $display("prefix_sum_bucket_search_core test failed");
        $finish;
    end

endmodule
